FILE: rtl/pmme_pkg.sv
// shared types, action codes and command and status bundles of the pixel mask map engine
package pmme_pkg;

    // field widths of the stream items
    localparam int ACT_W  = 4;
    localparam int CHIP_W = 5;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 7;

    // action codes
    localparam logic [ACT_W-1:0] ACT_SET_PIX   = 4'd0;
    localparam logic [ACT_W-1:0] ACT_CLR_PIX   = 4'd1;
    localparam logic [ACT_W-1:0] ACT_CLR_COL   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_CLR_ROW   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_CLR_CHIP  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_FILL_CHIP = 4'd5;
    localparam logic [ACT_W-1:0] ACT_FILL_ALL  = 4'd6;
    localparam logic [ACT_W-1:0] ACT_Q_PIX     = 4'd7;
    localparam logic [ACT_W-1:0] ACT_Q_CHIP    = 4'd8;
    localparam logic [ACT_W-1:0] ACT_Q_DCOL    = 4'd9;
    localparam logic [ACT_W-1:0] ACT_Q_COL     = 4'd10;
    localparam logic [ACT_W-1:0] ACT_Q_COL_ALL = 4'd11;
    localparam logic [ACT_W-1:0] ACT_FIND      = 4'd12;

    // probe pixel of the find action and columns per double column
    localparam int PROBE_PIXEL     = 20;
    localparam int COLS_PER_DOUBLE = 2;

    // rows examined per step of the bit locator
    localparam int GRP_W = 16;

    // position codes for the column and chip pointers
    localparam logic [2:0] POS_ITEM   = 3'd0;  // item chip, item column
    localparam logic [2:0] POS_CHIP0  = 3'd1;  // item chip, column 0
    localparam logic [2:0] POS_CHIP1  = 3'd2;  // item chip, column 1
    localparam logic [2:0] POS_PROBE  = 3'd3;  // item chip, probe column
    localparam logic [2:0] POS_DCOL   = 3'd4;  // item chip, first column of double column
    localparam logic [2:0] POS_ORIGIN = 3'd5;  // chip 0, column 0
    localparam logic [2:0] POS_COLX   = 3'd6;  // chip 0, item column

    // write data selection
    localparam logic [1:0] WR_ZERO = 2'd0;
    localparam logic [1:0] WR_ONES = 2'd1;
    localparam logic [1:0] WR_SET  = 2'd2;
    localparam logic [1:0] WR_CLR  = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       pos_en;
        logic [2:0] pos_sel;
        logic       step_col;
        logic       step_chip;
        logic       step_flat;
        logic       rd;
        logic       wr;
        logic [1:0] wr_sel;
        logic       hit_set;
        logic       found_probe;
        logic       loc_ld;
        logic       found_scan;
        logic       out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             err;
        logic             col_last;
        logic             chip_last;
        logic             scan_col_last;
        logic             dcol_last;
        logic             word_any;
        logic             pixel_bit;
        logic             probe_bit;
        logic             scan_any;
        logic             probe_on;
    } stat_t;

endpackage

FILE: rtl/pmme_ctrl.sv
// sequencer of the pixel mask map engine: handshakes and per-action step order
module pmme_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_tvalid,
    output logic              in_tready,
    output logic              out_tvalid,
    input  logic              out_tready,
    input  pmme_pkg::stat_t   stat,
    output pmme_pkg::cmd_t    cmd
);
    import pmme_pkg::*;

    localparam logic [4:0] S_CLEAR     = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_DECODE    = 5'd2;
    localparam logic [4:0] S_RMW_RD    = 5'd3;
    localparam logic [4:0] S_RMW_WR    = 5'd4;
    localparam logic [4:0] S_WR_ONE    = 5'd5;
    localparam logic [4:0] S_ROW_RD    = 5'd6;
    localparam logic [4:0] S_ROW_WR    = 5'd7;
    localparam logic [4:0] S_FILL      = 5'd8;
    localparam logic [4:0] S_FILL_ALL  = 5'd9;
    localparam logic [4:0] S_Q_RD      = 5'd10;
    localparam logic [4:0] S_Q_CHK     = 5'd11;
    localparam logic [4:0] S_SCAN_RD   = 5'd12;
    localparam logic [4:0] S_SCAN_CHK  = 5'd13;
    localparam logic [4:0] S_PROBE_RD  = 5'd14;
    localparam logic [4:0] S_PROBE_CHK = 5'd15;
    localparam logic [4:0] S_FIND_RD   = 5'd16;
    localparam logic [4:0] S_FIND_CHK  = 5'd17;
    localparam logic [4:0] S_LOC       = 5'd18;
    localparam logic [4:0] S_FINISH    = 5'd19;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       scan_last;
    logic       q_hit;

    assign in_tready  = (state_reg == S_IDLE);
    assign out_tvalid = out_valid_reg;

    // end of a query sweep and the hit test of single word queries
    always_comb
    begin
        case (stat.action)
            ACT_Q_CHIP: scan_last = stat.col_last;
            ACT_Q_DCOL: scan_last = stat.dcol_last;
            default:    scan_last = stat.chip_last;
        endcase
        q_hit = (stat.action == ACT_Q_PIX) ? stat.pixel_bit : stat.word_any;
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr     = 1'b1;
                cmd.wr_sel = WR_ZERO;
                if (stat.col_last && stat.chip_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.step_flat = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.pos_en = 1'b1;
                if (stat.err)
                begin
                    cmd.pos_en = 1'b0;
                    state_next = S_FINISH;
                end
                else
                begin
                    case (stat.action)
                        ACT_SET_PIX, ACT_CLR_PIX:
                        begin
                            cmd.pos_sel = POS_ITEM;
                            state_next  = S_RMW_RD;
                        end
                        ACT_CLR_COL:
                        begin
                            cmd.pos_sel = POS_ITEM;
                            state_next  = S_WR_ONE;
                        end
                        ACT_CLR_ROW:
                        begin
                            cmd.pos_sel = POS_CHIP0;
                            state_next  = S_ROW_RD;
                        end
                        ACT_CLR_CHIP, ACT_FILL_CHIP:
                        begin
                            cmd.pos_sel = POS_CHIP0;
                            state_next  = S_FILL;
                        end
                        ACT_FILL_ALL:
                        begin
                            cmd.pos_sel = POS_ORIGIN;
                            state_next  = S_FILL_ALL;
                        end
                        ACT_Q_PIX, ACT_Q_COL:
                        begin
                            cmd.pos_sel = POS_ITEM;
                            state_next  = S_Q_RD;
                        end
                        ACT_Q_CHIP:
                        begin
                            cmd.pos_sel = POS_CHIP0;
                            state_next  = S_SCAN_RD;
                        end
                        ACT_Q_DCOL:
                        begin
                            cmd.pos_sel = POS_DCOL;
                            state_next  = S_SCAN_RD;
                        end
                        ACT_Q_COL_ALL:
                        begin
                            cmd.pos_sel = POS_COLX;
                            state_next  = S_SCAN_RD;
                        end
                        ACT_FIND:
                        begin
                            if (stat.probe_on)
                            begin
                                cmd.pos_sel = POS_PROBE;
                                state_next  = S_PROBE_RD;
                            end
                            else
                            begin
                                cmd.pos_sel = POS_CHIP1;
                                state_next  = S_FIND_RD;
                            end
                        end
                        default:
                        begin
                            cmd.pos_en = 1'b0;
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_RMW_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                cmd.wr     = 1'b1;
                cmd.wr_sel = (stat.action == ACT_SET_PIX) ? WR_SET : WR_CLR;
                state_next = S_FINISH;
            end
            S_WR_ONE:
            begin
                cmd.wr     = 1'b1;
                cmd.wr_sel = WR_ZERO;
                state_next = S_FINISH;
            end
            S_ROW_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_ROW_WR;
            end
            S_ROW_WR:
            begin
                cmd.wr     = 1'b1;
                cmd.wr_sel = WR_CLR;
                if (stat.col_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step_col = 1'b1;
                    state_next   = S_ROW_RD;
                end
            end
            S_FILL:
            begin
                cmd.wr     = 1'b1;
                cmd.wr_sel = (stat.action == ACT_FILL_CHIP) ? WR_ONES : WR_ZERO;
                if (stat.col_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step_col = 1'b1;
                end
            end
            S_FILL_ALL:
            begin
                cmd.wr     = 1'b1;
                cmd.wr_sel = WR_ONES;
                if (stat.col_last && stat.chip_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step_flat = 1'b1;
                end
            end
            S_Q_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_Q_CHK;
            end
            S_Q_CHK:
            begin
                cmd.hit_set = q_hit;
                state_next  = S_FINISH;
            end
            S_SCAN_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (stat.word_any)
                begin
                    cmd.hit_set = 1'b1;
                    state_next  = S_FINISH;
                end
                else if (scan_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step_chip = (stat.action == ACT_Q_COL_ALL);
                    cmd.step_col  = (stat.action != ACT_Q_COL_ALL);
                    state_next    = S_SCAN_RD;
                end
            end
            S_PROBE_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                if (stat.probe_bit)
                begin
                    cmd.found_probe = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.pos_en  = 1'b1;
                    cmd.pos_sel = POS_CHIP1;
                    state_next  = S_FIND_RD;
                end
            end
            S_FIND_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                cmd.loc_ld = 1'b1;
                if (stat.scan_any)
                begin
                    state_next = S_LOC;
                end
                else if (stat.scan_col_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step_col = 1'b1;
                    state_next   = S_FIND_RD;
                end
            end
            S_LOC:
            begin
                cmd.found_scan = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // memory port is used for one access at a time
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.rd && cmd.wr))
        else $error("read and write issued together");

    // no store write while a new item can be taken
    assert property (@(posedge clk) disable iff (!rst_n) cmd.wr |-> !in_tready)
        else $error("store written while idle");

    // result register is never overwritten before its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_tready))
        else $error("pending result overwritten");

    // an accepted item is decoded in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_tvalid && in_tready) |=> (state_reg == S_DECODE))
        else $error("accepted item not decoded");

    // a result is loaded only from the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FINISH))
        else $error("result raised outside finish step");

endmodule

FILE: rtl/pmme_dpath.sv
// datapath of the pixel mask map engine: item registers, pointers, mask store and bit locator
module pmme_dpath
#(
    parameter int NUM_CHIPS = 16,
    parameter int NUM_COLS  = 52,
    parameter int NUM_ROWS  = 80
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pmme_pkg::ACT_W-1:0]    action,
    input  logic [pmme_pkg::CHIP_W-1:0]   chip_index,
    input  logic [pmme_pkg::COL_W-1:0]    col_index,
    input  logic [pmme_pkg::ROW_W-1:0]    row_index,
    input  pmme_pkg::cmd_t                cmd,
    output pmme_pkg::stat_t               stat,
    output logic                          hit,
    output logic [pmme_pkg::COL_W-1:0]    found_col,
    output logic [pmme_pkg::ROW_W-1:0]    found_row,
    output logic                          range_error
);
    import pmme_pkg::*;

    localparam int DEPTH    = NUM_CHIPS * NUM_COLS;
    localparam int AW       = $clog2(DEPTH);
    localparam int AFW      = CHIP_W + COL_W;
    localparam int DCOL_W   = COL_W + 2;
    localparam int NGRP     = (NUM_ROWS + GRP_W - 1) / GRP_W;
    localparam int PADW     = NGRP * GRP_W;
    localparam int GW       = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam bit PROBE_ON = (PROBE_PIXEL < NUM_COLS) && (PROBE_PIXEL < NUM_ROWS);

    // item registers
    logic [ACT_W-1:0]  act_reg;
    logic [CHIP_W-1:0] chip_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    // chip and column pointers
    logic [CHIP_W-1:0] cur_chip_reg;
    logic [CHIP_W-1:0] cur_chip_next;
    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;

    // mask store
    logic [NUM_ROWS-1:0] mem [DEPTH];
    logic [NUM_ROWS-1:0] rdata_reg;
    logic [NUM_ROWS-1:0] wdata;
    logic [AFW-1:0]      addr_full;
    logic [AW-1:0]       mem_addr;

    // result accumulators and output register
    logic              hit_reg;
    logic [COL_W-1:0]  fcol_reg;
    logic [ROW_W-1:0]  frow_reg;
    logic              out_hit_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic              out_err_reg;

    // bit locator
    logic [NUM_ROWS-1:0] scan_word;
    logic [PADW-1:0]     scan_pad;
    logic [NGRP-1:0]     scan_grp;
    logic [PADW-1:0]     loc_word_reg;
    logic [NGRP-1:0]     loc_grp_reg;
    logic [GW-1:0]       loc_sel;
    logic [GRP_W-1:0]    loc_chunk;
    logic [3:0]          loc_bit;
    logic [ROW_W-1:0]    loc_row;

    // range checks and helpers
    logic                chip_ok;
    logic                col_ok;
    logic                row_ok;
    logic                dcol_ok;
    logic [DCOL_W-1:0]   dcol_base;
    logic [NUM_ROWS-1:0] row_onehot;
    logic                probe_bit;
    logic                err;

    // range checks on the held item
    always_comb
    begin
        dcol_base = DCOL_W'(col_reg) * DCOL_W'(COLS_PER_DOUBLE);
        chip_ok   = {1'b0, chip_reg} < (CHIP_W + 1)'(NUM_CHIPS);
        col_ok    = {1'b0, col_reg} < (COL_W + 1)'(NUM_COLS);
        row_ok    = {1'b0, row_reg} < (ROW_W + 1)'(NUM_ROWS);
        dcol_ok   = (dcol_base + DCOL_W'(COLS_PER_DOUBLE - 1)) < DCOL_W'(NUM_COLS);
        case (act_reg)
            ACT_SET_PIX, ACT_CLR_PIX, ACT_Q_PIX:        err = !(chip_ok && col_ok && row_ok);
            ACT_CLR_COL, ACT_Q_COL:                     err = !(chip_ok && col_ok);
            ACT_CLR_ROW:                                err = !(chip_ok && row_ok);
            ACT_CLR_CHIP, ACT_FILL_CHIP, ACT_Q_CHIP,
            ACT_FIND:                                   err = !chip_ok;
            ACT_FILL_ALL:                               err = 1'b0;
            ACT_Q_DCOL:                                 err = !(chip_ok && dcol_ok);
            ACT_Q_COL_ALL:                              err = !col_ok;
            default:                                    err = 1'b1;
        endcase
    end

    // row decode and probe bit of the read word
    always_comb
    begin
        probe_bit = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row_onehot[r] = (row_reg == ROW_W'(r));
            if (r == PROBE_PIXEL)
            begin
                probe_bit = rdata_reg[r];
            end
        end
        probe_bit = probe_bit && PROBE_ON;
    end

    // edge rows masked off and per-group flags for the scan
    always_comb
    begin
        scan_word               = rdata_reg;
        scan_word[0]            = 1'b0;
        scan_word[NUM_ROWS-1]   = 1'b0;
        scan_pad                = PADW'(scan_word);
        for (int g = 0; g < NGRP; g++)
        begin
            scan_grp[g] = |scan_pad[g*GRP_W +: GRP_W];
        end
    end

    // status towards the controller
    always_comb
    begin
        stat.action        = act_reg;
        stat.err           = err;
        stat.col_last      = (cur_col_reg == COL_W'(NUM_COLS - 1));
        stat.chip_last     = (cur_chip_reg == CHIP_W'(NUM_CHIPS - 1));
        stat.scan_col_last = (cur_col_reg == COL_W'(NUM_COLS - 2));
        stat.dcol_last     = (DCOL_W'(cur_col_reg) ==
                              (dcol_base + DCOL_W'(COLS_PER_DOUBLE - 1)));
        stat.word_any      = |rdata_reg;
        stat.pixel_bit     = |(rdata_reg & row_onehot);
        stat.probe_bit     = probe_bit;
        stat.scan_any      = |scan_word;
        stat.probe_on      = PROBE_ON;
    end

    // pointer update
    always_comb
    begin
        cur_chip_next = cur_chip_reg;
        cur_col_next  = cur_col_reg;
        if (cmd.pos_en)
        begin
            case (cmd.pos_sel)
                POS_ITEM:
                begin
                    cur_chip_next = chip_reg;
                    cur_col_next  = col_reg;
                end
                POS_CHIP0:
                begin
                    cur_chip_next = chip_reg;
                    cur_col_next  = '0;
                end
                POS_CHIP1:
                begin
                    cur_chip_next = chip_reg;
                    cur_col_next  = COL_W'(1);
                end
                POS_PROBE:
                begin
                    cur_chip_next = chip_reg;
                    cur_col_next  = COL_W'(PROBE_PIXEL);
                end
                POS_DCOL:
                begin
                    cur_chip_next = chip_reg;
                    cur_col_next  = dcol_base[COL_W-1:0];
                end
                POS_COLX:
                begin
                    cur_chip_next = '0;
                    cur_col_next  = col_reg;
                end
                default:
                begin
                    cur_chip_next = '0;
                    cur_col_next  = '0;
                end
            endcase
        end
        else if (cmd.step_col)
        begin
            cur_col_next = cur_col_reg + COL_W'(1);
        end
        else if (cmd.step_chip)
        begin
            cur_chip_next = cur_chip_reg + CHIP_W'(1);
        end
        else if (cmd.step_flat)
        begin
            if (stat.col_last)
            begin
                cur_col_next  = '0;
                cur_chip_next = cur_chip_reg + CHIP_W'(1);
            end
            else
            begin
                cur_col_next = cur_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_chip_reg <= '0;
            cur_col_reg  <= '0;
        end
        else
        begin
            cur_chip_reg <= cur_chip_next;
            cur_col_reg  <= cur_col_next;
        end
    end

    // word address and write data
    always_comb
    begin
        addr_full = AFW'(cur_chip_reg) * AFW'(NUM_COLS) + AFW'(cur_col_reg);
        mem_addr  = addr_full[AW-1:0];
        case (cmd.wr_sel)
            WR_ZERO: wdata = '0;
            WR_ONES: wdata = '1;
            WR_SET:  wdata = rdata_reg | row_onehot;
            WR_CLR:  wdata = rdata_reg & ~row_onehot;
            default: wdata = '0;
        endcase
    end

    // mask store, one access a cycle, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[mem_addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // locate first set bit: group pick then bit pick within the group
    always_comb
    begin
        loc_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (loc_grp_reg[g])
            begin
                loc_sel = GW'(g);
            end
        end
        loc_chunk = loc_word_reg[loc_sel*GRP_W +: GRP_W];
        loc_bit   = '0;
        for (int b = GRP_W - 1; b >= 0; b--)
        begin
            if (loc_chunk[b])
            begin
                loc_bit = 4'(b);
            end
        end
        loc_row = ROW_W'({loc_sel, loc_bit});
    end

    // item capture, result accumulation and output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            chip_reg <= chip_index;
            col_reg  <= col_index;
            row_reg  <= row_index;
            hit_reg  <= 1'b0;
            fcol_reg <= '0;
            frow_reg <= '0;
        end
        if (cmd.hit_set)
        begin
            hit_reg <= 1'b1;
        end
        if (cmd.found_probe)
        begin
            hit_reg  <= 1'b1;
            fcol_reg <= COL_W'(PROBE_PIXEL);
            frow_reg <= ROW_W'(PROBE_PIXEL);
        end
        if (cmd.loc_ld)
        begin
            loc_word_reg <= scan_pad;
            loc_grp_reg  <= scan_grp;
        end
        if (cmd.found_scan)
        begin
            hit_reg  <= 1'b1;
            fcol_reg <= cur_col_reg;
            frow_reg <= loc_row;
        end
        if (cmd.out_load)
        begin
            out_hit_reg <= hit_reg;
            out_col_reg <= fcol_reg;
            out_row_reg <= frow_reg;
            out_err_reg <= err;
        end
    end

    assign hit         = out_hit_reg;
    assign found_col   = out_col_reg;
    assign found_row   = out_row_reg;
    assign range_error = out_err_reg;

endmodule

FILE: rtl/pixel_mask_map_engine.sv
// top level of the pixel mask map engine: stream ports around controller and datapath
// one item at a time; the single port of the mask store (one column word a cycle) sets the rate
// reset clears the store in a pass over every word; no input is taken until it ends
module pixel_mask_map_engine
#(
    parameter int NUM_CHIPS = 16,
    parameter int NUM_COLS  = 52,
    parameter int NUM_ROWS  = 80
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // action[3:0], chip_index[8:4], col_index[14:9], row_index[21:15]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // hit[0], found_col[6:1], found_row[13:7], range_error[14]
);
    import pmme_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic              hit;
    logic [COL_W-1:0]  found_col;
    logic [ROW_W-1:0]  found_row;
    logic              range_error;

    // sequencer
    pmme_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tvalid  (s_axis_tvalid),
        .in_tready  (s_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // store and datapath
    pmme_dpath #(
        .NUM_CHIPS (NUM_CHIPS),
        .NUM_COLS  (NUM_COLS),
        .NUM_ROWS  (NUM_ROWS)
    ) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (s_axis_tdata[3:0]),
        .chip_index  (s_axis_tdata[8:4]),
        .col_index   (s_axis_tdata[14:9]),
        .row_index   (s_axis_tdata[21:15]),
        .cmd         (cmd),
        .stat        (stat),
        .hit         (hit),
        .found_col   (found_col),
        .found_row   (found_row),
        .range_error (range_error)
    );

    // result packing
    assign m_axis_tdata = {1'b0, range_error, found_row, found_col, hit};

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the pixel mask map engine: directed table, then random actions
module tb_top;
    import pmme_pkg::*;

    localparam int NUM_CHIPS    = 16;
    localparam int NUM_COLS     = 52;
    localparam int NUM_ROWS     = 80;
    localparam int RANDOM_ITEMS = 1000;
    localparam int SETTLE_CYCLES = 2 * NUM_COLS + 8;

    // codes outside the action set
    localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 4'd13;
    localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 4'd15;

    // one command item, action in the lowest bits as on tdata
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHIP_W-1:0] chip;
        logic [ACT_W-1:0]  action;
    } mask_cmd_t;

    // one answer item, hit in the lowest bit as on tdata
    typedef struct packed {
        logic             range_error;
        logic [ROW_W-1:0] found_row;
        logic [COL_W-1:0] found_col;
        logic             hit;
    } mask_ans_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    // predicted enable bits, one row word per chip and column
    logic [NUM_ROWS-1:0] enable_map [NUM_CHIPS][NUM_COLS];

    mask_ans_t expected_answers [$];
    mask_cmd_t table_cmds [$];
    bit        table_known [$];
    mask_ans_t table_answers [$];

    int        error_count = 0;
    bit        quiet = 1'b0;
    mask_ans_t got_ans;
    mask_ans_t want_ans;

    pixel_mask_map_engine
    #(
        .NUM_CHIPS (NUM_CHIPS),
        .NUM_COLS  (NUM_COLS),
        .NUM_ROWS  (NUM_ROWS)
    )
    u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // apply one action to the predicted map and work out its answer
    function automatic mask_ans_t apply_mask_action(input mask_cmd_t c);
        mask_ans_t a;
        bit        chip_ok;
        bit        col_ok;
        bit        row_ok;
        bit        found;
        int        ch;
        int        cc;
        int        rr;
        a       = '0;
        chip_ok = int'(c.chip) < NUM_CHIPS;
        col_ok  = int'(c.col) < NUM_COLS;
        row_ok  = int'(c.row) < NUM_ROWS;
        ch      = int'(c.chip);
        case (c.action)
            ACT_SET_PIX, ACT_CLR_PIX, ACT_Q_PIX:
            begin
                if (!(chip_ok && col_ok && row_ok))
                    a.range_error = 1'b1;
                else if (c.action == ACT_SET_PIX)
                    enable_map[ch][c.col][c.row] = 1'b1;
                else if (c.action == ACT_CLR_PIX)
                    enable_map[ch][c.col][c.row] = 1'b0;
                else
                    a.hit = enable_map[ch][c.col][c.row];
            end
            ACT_CLR_COL:
            begin
                if (!(chip_ok && col_ok))
                    a.range_error = 1'b1;
                else
                    enable_map[ch][c.col] = '0;
            end
            ACT_CLR_ROW:
            begin
                if (!(chip_ok && row_ok))
                    a.range_error = 1'b1;
                else
                    for (cc = 0; cc < NUM_COLS; cc++)
                        enable_map[ch][cc][c.row] = 1'b0;
            end
            ACT_CLR_CHIP, ACT_FILL_CHIP:
            begin
                if (!chip_ok)
                    a.range_error = 1'b1;
                else
                    for (cc = 0; cc < NUM_COLS; cc++)
                        enable_map[ch][cc] = (c.action == ACT_FILL_CHIP) ? '1 : '0;
            end
            ACT_FILL_ALL:
            begin
                for (int k = 0; k < NUM_CHIPS; k++)
                    for (cc = 0; cc < NUM_COLS; cc++)
                        enable_map[k][cc] = '1;
            end
            ACT_Q_CHIP:
            begin
                if (!chip_ok)
                    a.range_error = 1'b1;
                else
                    for (cc = 0; cc < NUM_COLS; cc++)
                        if (|enable_map[ch][cc])
                            a.hit = 1'b1;
            end
            ACT_Q_DCOL:
            begin
                if (!chip_ok || int'(c.col) * COLS_PER_DOUBLE + 1 >= NUM_COLS)
                    a.range_error = 1'b1;
                else
                    for (cc = 0; cc < COLS_PER_DOUBLE; cc++)
                        if (|enable_map[ch][int'(c.col) * COLS_PER_DOUBLE + cc])
                            a.hit = 1'b1;
            end
            ACT_Q_COL:
            begin
                if (!(chip_ok && col_ok))
                    a.range_error = 1'b1;
                else
                    a.hit = |enable_map[ch][c.col];
            end
            ACT_Q_COL_ALL:
            begin
                if (!col_ok)
                    a.range_error = 1'b1;
                else
                    for (int k = 0; k < NUM_CHIPS; k++)
                        if (|enable_map[k][c.col])
                            a.hit = 1'b1;
            end
            ACT_FIND:
            begin
                if (!chip_ok)
                    a.range_error = 1'b1;
                else if (PROBE_PIXEL < NUM_COLS && PROBE_PIXEL < NUM_ROWS &&
                         enable_map[ch][PROBE_PIXEL][PROBE_PIXEL])
                begin
                    a.hit       = 1'b1;
                    a.found_col = COL_W'(PROBE_PIXEL);
                    a.found_row = ROW_W'(PROBE_PIXEL);
                end
                else
                begin
                    // column by column scan, edge pixels skipped
                    found = 1'b0;
                    for (cc = 1; cc + 1 < NUM_COLS && !found; cc++)
                        for (rr = 1; rr + 1 < NUM_ROWS && !found; rr++)
                            if (enable_map[ch][cc][rr])
                            begin
                                a.hit       = 1'b1;
                                a.found_col = COL_W'(cc);
                                a.found_row = ROW_W'(rr);
                                found       = 1'b1;
                            end
                end
            end
            default:
                a.range_error = 1'b1;
        endcase
        return a;
    endfunction

    // random index near the edges or at the probe pixel, in range, or anywhere in the field
    function automatic int pick_index(input int count, input int field_max);
        int sel;
        sel = $urandom_range(99);
        if (sel < 12)
        begin
            case ($urandom_range(4))
                0: return 0;
                1: return 1;
                2: return PROBE_PIXEL;
                3: return count - 2;
                default: return count - 1;
            endcase
        end
        else if (sel < 94)
            return $urandom_range(count - 1);
        return $urandom_range(field_max);
    endfunction

    // random command, mostly on a few chips so that the map fills up in places
    function automatic mask_cmd_t random_cmd();
        mask_cmd_t c;
        int        w;
        if ($urandom_range(99) < 70)
            c.chip = CHIP_W'($urandom_range(3));
        else if ($urandom_range(99) < 85)
            c.chip = CHIP_W'($urandom_range(NUM_CHIPS - 1));
        else
            c.chip = CHIP_W'($urandom_range(31));
        c.col = COL_W'(pick_index(NUM_COLS, 63));
        c.row = ROW_W'(pick_index(NUM_ROWS, 127));
        w = $urandom_range(999);
        if (w < 180)      c.action = ACT_SET_PIX;
        else if (w < 260) c.action = ACT_CLR_PIX;
        else if (w < 300) c.action = ACT_CLR_COL;
        else if (w < 340) c.action = ACT_CLR_ROW;
        else if (w < 370) c.action = ACT_CLR_CHIP;
        else if (w < 380) c.action = ACT_FILL_CHIP;
        else if (w < 385) c.action = ACT_FILL_ALL;
        else if (w < 520) c.action = ACT_Q_PIX;
        else if (w < 580) c.action = ACT_Q_CHIP;
        else if (w < 640) c.action = ACT_Q_DCOL;
        else if (w < 700) c.action = ACT_Q_COL;
        else if (w < 750) c.action = ACT_Q_COL_ALL;
        else if (w < 960) c.action = ACT_FIND;
        else              c.action = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        if (c.action == ACT_Q_DCOL && $urandom_range(99) < 90)
            c.col = COL_W'($urandom_range(NUM_COLS / 2 - 1));
        return c;
    endfunction

    // one row of the directed table; a known answer replaces the predicted one
    task automatic table_row(input logic [ACT_W-1:0] action, input int chip, input int col,
                             input int row, input bit known = 1'b0, input bit hit = 1'b0,
                             input bit err = 1'b0);
        mask_cmd_t c;
        mask_ans_t a;
        c.action = action;
        c.chip   = CHIP_W'(chip);
        c.col    = COL_W'(col);
        c.row    = ROW_W'(row);
        a             = '0;
        a.hit         = hit;
        a.range_error = err;
        table_cmds.push_back(c);
        table_known.push_back(known);
        table_answers.push_back(a);
    endtask

    // offer one command, sometimes after a random gap, and record its answer on transfer
    task automatic send_cmd(input mask_cmd_t c, input bit known, input mask_ans_t want);
        mask_ans_t predicted;
        if (!quiet && $urandom_range(99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 23);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, c};
        do @(posedge clk); while (!s_axis_tready);
        predicted = apply_mask_action(c);
        expected_answers.push_back(known ? want : predicted);
    endtask

    // hold the sender off until every answer is back
    task automatic wait_for_answers();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_answers.size() != 0);
    endtask

    // receiver stalls
    always @(posedge clk)
        m_axis_tready <= quiet || ($urandom_range(99) >= 23);

    // answer checking
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            got_ans = m_axis_tdata[14:0];
            if (expected_answers.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: answer with none pending: %h", $time, got_ans);
            end
            else
            begin
                want_ans = expected_answers.pop_front();
                if (got_ans.hit !== want_ans.hit ||
                    got_ans.found_col !== want_ans.found_col ||
                    got_ans.found_row !== want_ans.found_row ||
                    got_ans.range_error !== want_ans.range_error)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"%0t: expected hit %0d col %0d row %0d err %0d, ",
                                  "got hit %0d col %0d row %0d err %0d"},
                                 $time, want_ans.hit, want_ans.found_col, want_ans.found_row,
                                 want_ans.range_error, got_ans.hit, got_ans.found_col,
                                 got_ans.found_row, got_ans.range_error);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        for (int k = 0; k < NUM_CHIPS; k++)
            for (int cc = 0; cc < NUM_COLS; cc++)
                enable_map[k][cc] = '0;

        // directed table: empty map, extremes, find cases, unused indices, range errors
        table_row(ACT_Q_PIX, 0, 0, 0, 1'b1, 1'b0, 1'b0);
        table_row(ACT_FIND, 0, 0, 0, 1'b1, 1'b0, 1'b0);
        table_row(ACT_Q_CHIP, NUM_CHIPS - 1, 0, 0, 1'b1, 1'b0, 1'b0);
        table_row(ACT_SET_PIX, NUM_CHIPS - 1, NUM_COLS - 1, NUM_ROWS - 1);
        table_row(ACT_Q_PIX, NUM_CHIPS - 1, NUM_COLS - 1, NUM_ROWS - 1);
        table_row(ACT_Q_DCOL, NUM_CHIPS - 1, NUM_COLS / 2 - 1, 0);
        table_row(ACT_Q_COL_ALL, 0, NUM_COLS - 1, 0);
        table_row(ACT_SET_PIX, 0, 0, 0);
        table_row(ACT_FIND, 0, 0, 0);
        table_row(ACT_SET_PIX, 0, 1, 1);
        table_row(ACT_SET_PIX, 0, PROBE_PIXEL, PROBE_PIXEL);
        table_row(ACT_FIND, 0, 0, 0);
        table_row(ACT_CLR_PIX, 0, PROBE_PIXEL, PROBE_PIXEL);
        table_row(ACT_FIND, 0, 63, 127);
        table_row(ACT_CLR_COL, NUM_CHIPS - 1, NUM_COLS - 1, 127);
        table_row(ACT_Q_COL, NUM_CHIPS - 1, NUM_COLS - 1, 0);
        table_row(ACT_CLR_ROW, 0, 63, 1);
        table_row(ACT_FILL_CHIP, 3, 63, 127);
        table_row(ACT_Q_CHIP, 3, 63, 127);
        table_row(ACT_CLR_CHIP, 3, 0, 0);
        table_row(ACT_FILL_ALL, 31, 63, 127);
        table_row(ACT_FIND, 31, 0, 0, 1'b1, 1'b0, 1'b1);
        table_row(ACT_Q_DCOL, 0, NUM_COLS / 2, 0, 1'b1, 1'b0, 1'b1);
        table_row(ACT_SET_PIX, 31, 63, 127, 1'b1, 1'b0, 1'b1);
        table_row(ACT_CLR_ROW, 0, 0, NUM_ROWS, 1'b1, 1'b0, 1'b1);
        table_row(ACT_UNUSED_HI, 31, 63, 127, 1'b1, 1'b0, 1'b1);
        table_row(ACT_UNUSED_LO, 0, 0, 0, 1'b1, 1'b0, 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < table_cmds.size(); n++)
            send_cmd(table_cmds[n], table_known[n], table_answers[n]);
        wait_for_answers();

        // random actions, with a stretch free of stalls and an occasional full drain
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet <= (n >= 400 && n < 600);
            if (n % 250 == 125)
                wait_for_answers();
            send_cmd(random_cmd(), 1'b0, '0);
        end
        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pmme_pkg.sv
rtl/pmme_ctrl.sv
rtl/pmme_dpath.sv
rtl/pixel_mask_map_engine.sv
verif/tb_top.sv
